// ----- src/per_key_token_bucket_limiter_core_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef PER_KEY_TOKEN_BUCKET_LIMITER_CORE_MACROS_SVH
`define PER_KEY_TOKEN_BUCKET_LIMITER_CORE_MACROS_SVH

// same-cycle implication
`define PKBL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PKBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pkbl_pkg.sv -----
// package: types and constants of the per-key token bucket limiter
`timescale 1ns / 1ps
package pkbl_pkg;

	localparam int KEY_W = 32;
	localparam int TOK_W = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	typedef enum logic {
		CMD_REQUEST = 1'b0,
		CMD_TICK    = 1'b1
	} cmd_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKET_CAP  = 4'd0,
		REG_REFILL_RATE = 4'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [TOK_W-1:0] tokens;
	} entry_t;

	typedef struct packed {
		logic [TOK_W-1:0] bucket_cap;
		logic [TOK_W-1:0] refill_rate;
	} cfg_t;

	typedef struct packed {
		logic granted;
		logic new_bucket;
	} rslt_t;

	localparam logic [TOK_W-1:0] BUCKET_CAP_RST  = 16'd10;
	localparam logic [TOK_W-1:0] REFILL_RATE_RST = 16'd1;

endpackage

// ----- src/pkbl_if.sv -----
// channel interfaces: input items, result items, configuration writes
`timescale 1ns / 1ps
interface pkbl_in_if import pkbl_pkg::*; ();
	logic             valid;
	logic             ready;
	cmd_e_t           cmd;
	logic [KEY_W-1:0] ip_addr;

	modport source (output valid, output cmd, output ip_addr, input ready);
	modport sink (input valid, input cmd, input ip_addr, output ready);
endinterface

interface pkbl_out_if;
	logic valid;
	logic ready;
	logic granted;
	logic new_bucket;

	modport source (output valid, output granted, output new_bucket, input ready);
	modport sink (input valid, input granted, input new_bucket, output ready);
endinterface

interface pkbl_cfg_if import pkbl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/pkbl_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module pkbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/pkbl_engine.sv -----
// table engine: clearing pass, scan of the bucket memory, update and result
`timescale 1ns / 1ps
module pkbl_engine import pkbl_pkg::*; #(
	parameter int TABLE_SIZE = 64,
	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  cmd_e_t                  in_cmd,
	input  logic [KEY_W-1:0]        in_addr,
	output logic                    rslt_valid,
	output rslt_t                   rslt,
	input  logic                    slot_free,
	output logic                    ram_we,
	output logic [IDX_W-1:0]        ram_waddr,
	output logic [$bits(entry_t)-1:0] ram_wdata,
	output logic                    ram_re,
	output logic [IDX_W-1:0]        ram_raddr,
	input  logic [$bits(entry_t)-1:0] ram_rdata
);

	state_t           state_q, state_next;
	logic [IDX_W-1:0] cnt_q;
	logic             last;
	cmd_e_t           op_q;
	logic [KEY_W-1:0] addr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [TOK_W-1:0] hit_tok_q;
	entry_t           rd_ent;
	entry_t           wr_ent;
	logic [TOK_W:0]   sum;
	logic [TOK_W-1:0] start_tok;

	assign last = (cnt_q == IDX_W'(TABLE_SIZE - 1));
	assign rd_ent = entry_t'(ram_rdata);
	assign ram_wdata = wr_ent;
	assign ram_raddr = cnt_q;
	assign sum = {1'b0, rd_ent.tokens} + {1'b0, cfg.refill_rate};
	assign start_tok = (cfg.bucket_cap != '0) ? cfg.bucket_cap - TOK_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready = 1'b0;
		ram_re = 1'b0;
		ram_we = 1'b0;
		ram_waddr = rd_idx_s1;
		wr_ent = '0;
		rslt_valid = 1'b0;
		rslt = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q;
				if (last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (in_cmd == CMD_TICK || in_addr != '0)) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_next = (op_q == CMD_TICK) ? ST_IDLE : ST_APPLY;
			end
			ST_APPLY: begin
				if (slot_free) begin
					rslt_valid = 1'b1;
					state_next = ST_IDLE;
					if (hit_q) begin
						if (hit_tok_q != '0) begin
							ram_we = 1'b1;
							ram_waddr = hit_idx_q;
							wr_ent = '{vld: 1'b1, key: addr_q, tokens: hit_tok_q - TOK_W'(1)};
							rslt.granted = 1'b1;
						end
					end else if (free_q) begin
						ram_we = 1'b1;
						ram_waddr = free_idx_q;
						wr_ent = '{vld: 1'b1, key: addr_q, tokens: start_tok};
						rslt.granted = 1'b1;
						rslt.new_bucket = 1'b1;
					end
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
		// tick write-back in the cycle after the read
		if (rd_vld_s1 && op_q == CMD_TICK && rd_ent.vld) begin
			ram_we = 1'b1;
			ram_waddr = rd_idx_s1;
			if (sum > {1'b0, cfg.bucket_cap}) begin
				wr_ent = '0;
			end else begin
				wr_ent = '{vld: 1'b1, key: rd_ent.key, tokens: sum[TOK_W-1:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			op_q <= CMD_REQUEST;
		end else begin
			rd_vld_s1 <= ram_re;
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= last ? '0 : cnt_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= in_cmd;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_vld_s1 && op_q == CMD_REQUEST) begin
				if (rd_ent.vld) begin
					if (!hit_q && rd_ent.key == addr_q) begin
						hit_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (state_q == ST_IDLE && in_valid) begin
			addr_q <= in_addr;
		end else if (rd_vld_s1 && op_q == CMD_REQUEST) begin
			if (rd_ent.vld) begin
				if (!hit_q && rd_ent.key == addr_q) begin
					hit_idx_q <= rd_idx_s1;
					hit_tok_q <= rd_ent.tokens;
				end
			end else if (!free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

endmodule

// ----- src/per_key_token_bucket_limiter_core.sv -----
// Per-key token bucket limiter: a table of TABLE_SIZE buckets keyed by 32-bit
// address, held in one memory of {valid, key, tokens} rows. Every request with
// a nonzero address and every refill tick walks the whole table through the
// single read port, one entry per cycle; a tick writes the update of each entry
// back in the cycle after its read, and a request then updates the hit or
// claimed entry and loads the result register, waiting while the previous
// result item still waits unaccepted in the result register. A request from
// address zero is taken and gives no result. After reset a clearing pass
// zeroes the memory; input items are held off until it ends, while
// configuration writes are taken at any time.
`timescale 1ns / 1ps
module per_key_token_bucket_limiter_core import pkbl_pkg::*; #(
	parameter int TABLE_SIZE = 64
) (
	input logic        clk,
	input logic        arst_n,
	pkbl_in_if.sink    in_ch,
	pkbl_out_if.source out_ch,
	pkbl_cfg_if.sink   cfg
);

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int ENT_W = $bits(entry_t);

	cfg_t              cfg_q;
	logic              out_valid_q;
	rslt_t             out_rslt_q;
	logic              slot_free;
	logic              rslt_valid;
	rslt_t             rslt;
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [ENT_W-1:0]  ram_wdata, ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bucket_cap <= BUCKET_CAP_RST;
			cfg_q.refill_rate <= REFILL_RATE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_BUCKET_CAP:  cfg_q.bucket_cap <= TOK_W'(cfg.data);
				REG_REFILL_RATE: cfg_q.refill_rate <= TOK_W'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	// result register
	assign slot_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.granted = out_rslt_q.granted;
	assign out_ch.new_bucket = out_rslt_q.new_bucket;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_valid) begin
			out_rslt_q <= rslt;
		end
	end

	pkbl_engine #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_cmd    (in_ch.cmd),
		.in_addr   (in_ch.ip_addr),
		.rslt_valid(rslt_valid),
		.rslt      (rslt),
		.slot_free (slot_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pkbl_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ----- src/pkbl_checker.sv -----
// port-level checker for the limiter top level, with its bind
`timescale 1ns / 1ps
`include "per_key_token_bucket_limiter_core_macros.svh"
module pkbl_checker import pkbl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input cmd_e_t           in_cmd,
	input logic [KEY_W-1:0] in_ip_addr,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_granted,
	input logic             out_new_bucket
);

	// a stalled result holds
	`PKBL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_granted) && $stable(out_new_bucket), "result item dropped or changed while stalled")

	// a tick or a real request occupies the block
	`PKBL_ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_valid && in_ready && (in_cmd == CMD_TICK || in_ip_addr != '0), !in_ready, "input accepted while a scan is running")

	// a result only appears at the end of a scan
	`PKBL_ASSERT_IMPLY(a_rslt_after_scan, clk, arst_n, $rose(out_valid), $past(!in_ready), "result item without a scan")

	// a new bucket always grants
	`PKBL_ASSERT_IMPLY(a_new_granted, clk, arst_n, out_valid, !out_new_bucket || out_granted, "new bucket reported as refused")

endmodule

bind per_key_token_bucket_limiter_core pkbl_checker u_pkbl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_cmd        (in_ch.cmd),
	.in_ip_addr    (in_ch.ip_addr),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_granted   (out_ch.granted),
	.out_new_bucket(out_ch.new_bucket)
);
